/* hdl/stt_pkg.sv */
// Shared definitions for the soft timer table: sizes, codes, controller
// states and the command/status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package stt_pkg;

  // Table geometry.
  localparam int SLOTS       = 8;
  localparam int FLAGGED_IDS = 4;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Field widths.
  localparam int ID_W     = 8;
  localparam int COUNT_W  = 16;
  localparam int MASK_W   = 4;
  localparam int MASK_SEL = $clog2(MASK_W);
  localparam int STATUS_W = 2;

  // An id of all ones marks an empty slot.
  localparam logic [ID_W-1:0] EMPTY_ID = {ID_W{1'b1}};

  // Command codes.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_TICK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RELOADED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_PLACED   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_FINISH
  } stt_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the incoming beat and restart the scan
    logic step;     // visit the slot under the scan index
    logic commit;   // apply a set and settle the status code
    logic publish;  // move the result into the output register
  } stt_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_slot;  // the scan index sits on the final slot
    logic out_free;   // the output register can take a result now
  } stt_stat_t;

endpackage

/* hdl/stt_controller.sv */
// Controller state machine for the soft timer table.
// Depends on stt_pkg for the state type and the command/status bundles.
`timescale 1ns / 1ps

module stt_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  output stt_pkg::stt_ctrl_t ctrl,
  input  stt_pkg::stt_stat_t stat
);
  import stt_pkg::*;

  stt_state_t state;
  stt_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.last_slot) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl       = '0;
    item_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        item_stall = rst;
        ctrl.load  = item_valid && !rst;
      end
      ST_SCAN: begin
        ctrl.step = 1'b1;
      end
      ST_COMMIT: begin
        ctrl.commit = 1'b1;
      end
      ST_FINISH: begin
        ctrl.publish = stat.out_free;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

endmodule

/* hdl/stt_datapath.sv */
// Datapath for the soft timer table: slot store, scan index, search flags,
// expiry mask accumulator and the output register.
// Depends on stt_pkg for sizes, codes and the command/status bundles.
`timescale 1ns / 1ps

module stt_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  stt_pkg::stt_ctrl_t            ctrl,
  output stt_pkg::stt_stat_t            stat,
  input  logic                          cmd,
  input  logic [stt_pkg::ID_W-1:0]      timer_id,
  input  logic [stt_pkg::COUNT_W-1:0]   duration,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [stt_pkg::MASK_W-1:0]    expired_mask,
  output logic [stt_pkg::STATUS_W-1:0]  status
);
  import stt_pkg::*;

  logic [ID_W-1:0]    slot_ident [SLOTS];
  logic [COUNT_W-1:0] slot_count [SLOTS];

  logic                req_cmd;
  logic [ID_W-1:0]     req_id;
  logic [COUNT_W-1:0]  req_dur;
  logic [IDX_W-1:0]    idx;
  logic                match_found;
  logic [IDX_W-1:0]    match_idx;
  logic                empty_found;
  logic [IDX_W-1:0]    empty_idx;
  logic [MASK_W-1:0]   mask;
  logic [STATUS_W-1:0] done_status;

  logic [ID_W-1:0]    cur_id;
  logic [COUNT_W-1:0] cur_count;
  logic               cur_occupied;
  logic               cur_zero;
  logic               tick_step;
  logic               flag_hit;
  logic               set_ok;
  logic               set_write;
  logic [IDX_W-1:0]   wr_idx;

  assign cur_id       = slot_ident[idx];
  assign cur_count    = slot_count[idx];
  assign cur_occupied = (cur_id != EMPTY_ID);
  assign cur_zero     = (cur_count == '0);
  assign tick_step    = ctrl.step && (req_cmd == CMD_TICK) && cur_occupied;
  assign flag_hit     = (cur_id < ID_W'(FLAGGED_IDS)) && (cur_id < ID_W'(MASK_W));

  // A set never writes the reserved id; it reloads a match first, then a free slot.
  assign set_ok    = (req_id != EMPTY_ID) && (match_found || empty_found);
  assign set_write = ctrl.commit && (req_cmd == CMD_SET) && set_ok;
  assign wr_idx    = match_found ? match_idx : empty_idx;

  assign stat.last_slot = (idx == IDX_W'(SLOTS - 1));
  assign stat.out_free  = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_ident[i] <= EMPTY_ID;
      end
    end else if (tick_step && cur_zero) begin
      slot_ident[idx] <= EMPTY_ID;
    end else if (set_write && !match_found) begin
      slot_ident[empty_idx] <= req_id;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_step && !cur_zero) begin
      slot_count[idx] <= cur_count - COUNT_W'(1);
    end else if (set_write) begin
      slot_count[wr_idx] <= req_dur;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      req_cmd     <= cmd;
      req_id      <= timer_id;
      req_dur     <= duration;
      idx         <= '0;
      match_found <= 1'b0;
      match_idx   <= '0;
      empty_found <= 1'b0;
      empty_idx   <= '0;
      mask        <= '0;
    end else if (ctrl.step) begin
      idx <= (stat.last_slot) ? '0 : idx + IDX_W'(1);
      if (req_cmd == CMD_SET) begin
        if (!match_found && (cur_id == req_id)) begin
          match_found <= 1'b1;
          match_idx   <= idx;
        end
        if (!empty_found && !cur_occupied) begin
          empty_found <= 1'b1;
          empty_idx   <= idx;
        end
      end else if (tick_step && cur_zero && flag_hit) begin
        mask <= mask | (MASK_W'(1) << cur_id[MASK_SEL-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      if (req_cmd == CMD_TICK) begin
        done_status <= STATUS_TICK;
      end else if (req_id == EMPTY_ID) begin
        done_status <= STATUS_DROPPED;
      end else if (match_found) begin
        done_status <= STATUS_RELOADED;
      end else if (empty_found) begin
        done_status <= STATUS_PLACED;
      end else begin
        done_status <= STATUS_DROPPED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctrl.publish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.publish) begin
      expired_mask <= (req_cmd == CMD_TICK) ? mask : '0;
      status       <= done_status;
    end
  end

endmodule

/* hdl/soft_timer_table.sv */
// Top level of the soft timer table: ties the controller to the datapath.
// Depends on stt_pkg, stt_controller and stt_datapath.
`timescale 1ns / 1ps

// The soft timer table keeps up to SLOTS software timers, each an 8-bit id
// with a 16-bit remaining count, and takes one command beat at a time. A tick
// beat (cmd 0) decrements every running count; a timer whose count is already
// zero on a tick expires, frees its slot and, for ids 0 to 3, raises its bit in
// expired_mask, so a timer loaded with N fires on tick N+1. A set beat (cmd 1)
// reloads the first slot holding the same id, or else claims the first free
// slot; a full table or the reserved id 255 drops the request with status 3.
// Every command beat yields exactly one result beat. A command runs through
// these steps in order: the beat is captured, a single scan index walks the
// table slot by slot, a set is applied and the status settled, and the output
// register is loaded. The output register holds a result while the downstream
// side stalls, and the next command beat can already be captured during that
// time; it then finishes only once the waiting result has been taken. After
// reset every slot is empty.
module soft_timer_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          cmd,
  input  logic [stt_pkg::ID_W-1:0]      timer_id,
  input  logic [stt_pkg::COUNT_W-1:0]   duration,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [stt_pkg::MASK_W-1:0]    expired_mask,
  output logic [stt_pkg::STATUS_W-1:0]  status
);
  import stt_pkg::*;

  stt_ctrl_t ctrl;
  stt_stat_t stat;

  // The controller sequences capture, scan, commit and publish.
  stt_controller u_controller (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .ctrl       (ctrl),
    .stat       (stat)
  );

  // The datapath owns the slot store and the output register.
  stt_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .cmd          (cmd),
    .timer_id     (timer_id),
    .duration     (duration),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .expired_mask (expired_mask),
    .status       (status)
  );

endmodule

/* hdl/stt_checker.sv */
// Port-level checks for the soft timer table, bound to the top level.
// Depends on stt_pkg for field widths and status codes.
`timescale 1ns / 1ps

module stt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_stall,
  input logic                          result_valid,
  input logic                          result_stall,
  input logic [stt_pkg::MASK_W-1:0]    expired_mask,
  input logic [stt_pkg::STATUS_W-1:0]  status
);
  import stt_pkg::*;

  // A held result beat stays valid.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped while stalled");

  // A held result beat keeps its payload.
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(expired_mask) && $stable(status))
    else $error("result payload changed while stalled");

  // Only a tick reports expiries.
  a_mask_tick_only: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != STATUS_TICK) |-> expired_mask == '0)
    else $error("expiry mask set on a set result");

  // The block works on one command at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("second command accepted during a scan");

endmodule

bind soft_timer_table stt_checker u_stt_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .expired_mask (expired_mask),
  .status       (status)
);
